>>> hdl/lkvc_pkg.sv
// shared constants for the lru key-value cache
`default_nettype none

package lkvc_pkg;

   // widths of the item fields on the ports
   localparam int FIELD_W = 32;

   // default geometry
   localparam int DEF_CAPACITY    = 16;
   localparam int DEF_KEY_WIDTH   = 32;
   localparam int DEF_VALUE_WIDTH = 32;

   // request operation codes
   localparam logic OP_LOOKUP = 1'b0;
   localparam logic OP_INSERT = 1'b1;

endpackage

`default_nettype wire

>>> hdl/lru_key_value_cache.sv
// fully associative key-value cache with lru replacement, one entry memory
//
// usage:
//   req channel (req_valid / req_stall) carries one item: operation (lookup or
//   insert), key and value. rsp channel (rsp_valid / rsp_stall) returns one
//   item per request: hit, data (stored word on a lookup hit, else zero) and
//   evicted (an insert replaced the least recent entry).
//   an item moves at a clock edge where valid is high and stall is low.
// sequence:
//   one request at a time: a scan pass reads the entries one per cycle to match
//   the key, then an update pass rewrites each entry's age, key and value.
//   a lookup miss goes from the scan pass straight to the result; any other
//   request runs both passes. the next item is taken in the idle state that
//   follows the loading of the result
// reset:
//   synchronous, active high. all valid bits clear, so the cache starts
//   empty; memory contents are not cleared and need no clearing pass.
// stall:
//   a result waits in the output register while rsp_stall is high; the next
//   request is still taken and its result waits until the register frees
`default_nettype none

module lru_key_value_cache #(
   parameter int CAPACITY    = lkvc_pkg::DEF_CAPACITY,
   parameter int KEY_WIDTH   = lkvc_pkg::DEF_KEY_WIDTH,
   parameter int VALUE_WIDTH = lkvc_pkg::DEF_VALUE_WIDTH
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_stall,
   input  wire logic                         req_operation,
   input  wire logic [lkvc_pkg::FIELD_W-1:0] req_key,
   input  wire logic [lkvc_pkg::FIELD_W-1:0] req_value,
   output logic                              rsp_valid,
   input  wire logic                         rsp_stall,
   output logic                              rsp_hit,
   output logic      [lkvc_pkg::FIELD_W-1:0] rsp_data,
   output logic                              rsp_evicted
);

   // index / age width, pass counter width
   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW = $clog2(CAPACITY + 2);
   // how many port bits reach the stored key and value
   localparam int KI = (KEY_WIDTH < lkvc_pkg::FIELD_W) ? KEY_WIDTH : lkvc_pkg::FIELD_W;
   localparam int VI = (VALUE_WIDTH < lkvc_pkg::FIELD_W) ? VALUE_WIDTH : lkvc_pkg::FIELD_W;

   localparam logic [CW-1:0] CNT_CAP    = CW'(CAPACITY);
   localparam logic [CW-1:0] CNT_LAST   = CW'(CAPACITY + 1);
   localparam logic [AW-1:0] AGE_OLDEST = AW'(CAPACITY - 1);

   typedef struct packed {
      logic [KEY_WIDTH-1:0]   key;
      logic [VALUE_WIDTH-1:0] value;
      logic [AW-1:0]          age;
   } entry_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_UPDATE,
      ST_FINISH
   } state_type;

   // entry memory: key, value and age rank of each entry
   entry_type mem [CAPACITY];

   state_type              state_ff;
   logic [CW-1:0]          cnt_ff;
   logic                   rd_vld_ff;
   logic [AW-1:0]          rd_idx_ff;
   entry_type              rd_data_ff;
   logic [CAPACITY-1:0]    valid_ff;

   // request being worked on
   logic                   op_ff;
   logic [KEY_WIDTH-1:0]   key_ff;
   logic [VALUE_WIDTH-1:0] value_ff;

   // scan results
   logic                   found_ff;
   logic                   free_found_ff;
   logic [AW-1:0]          slot_ff;       // hit entry, then the entry to write
   logic [AW-1:0]          free_slot_ff;
   logic [AW-1:0]          old_slot_ff;
   logic [AW-1:0]          limit_ff;      // entries younger than this age by one
   logic                   age_all_ff;    // fill of a free entry: every entry ages
   logic                   evict_ff;
   logic [VALUE_WIDTH-1:0] hit_val_ff;

   // output register
   logic                   rsp_valid_ff;
   logic                   rsp_hit_ff;
   logic [lkvc_pkg::FIELD_W-1:0] rsp_data_ff;
   logic                   rsp_evicted_ff;

   logic                   issue;
   logic [AW-1:0]          rd_addr;
   logic                   rd_entry_valid;
   logic                   key_match;
   logic                   is_slot;
   logic                   age_up;
   logic                   wr_en;
   entry_type              wr_data;

   // one read per cycle while a pass walks the entries
   assign issue   = ((state_ff == ST_SCAN) || (state_ff == ST_UPDATE)) && (cnt_ff < CNT_CAP);
   assign rd_addr = issue ? cnt_ff[AW-1:0] : '0;

   assign rd_entry_valid = valid_ff[rd_idx_ff];
   assign key_match      = rd_entry_valid && (rd_data_ff.key == key_ff);
   assign is_slot        = (rd_idx_ff == slot_ff);
   assign age_up         = rd_entry_valid && !is_slot &&
                           (age_all_ff || (rd_data_ff.age < limit_ff));

   // modify step of the update pass
   always_comb begin
      wr_data = rd_data_ff;
      if (is_slot) begin
         wr_data.age = '0;
         if (op_ff == lkvc_pkg::OP_INSERT) begin
            wr_data.key   = key_ff;
            wr_data.value = value_ff;
         end
      end else if (age_up) begin
         wr_data.age = rd_data_ff.age + AW'(1);
      end
   end

   // write back the entry read in the previous cycle; the next read is another entry
   assign wr_en = (state_ff == ST_UPDATE) && rd_vld_ff;

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
      if (wr_en) begin
         mem[rd_idx_ff] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rd_vld_ff    <= 1'b0;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rd_vld_ff <= issue;
         rd_idx_ff <= rd_addr;

         // finish loads the output register itself
         if (rsp_valid_ff && !rsp_stall && (state_ff != ST_FINISH)) begin
            rsp_valid_ff <= 1'b0;
         end

         case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  op_ff         <= req_operation;
                  key_ff        <= KEY_WIDTH'(req_key[KI-1:0]);
                  value_ff      <= VALUE_WIDTH'(req_value[VI-1:0]);
                  found_ff      <= 1'b0;
                  free_found_ff <= 1'b0;
                  evict_ff      <= 1'b0;
                  cnt_ff        <= '0;
                  state_ff      <= ST_SCAN;
               end
            end
            ST_SCAN: begin
               if (rd_vld_ff) begin
                  if (key_match && !found_ff) begin
                     found_ff   <= 1'b1;
                     slot_ff    <= rd_idx_ff;
                     limit_ff   <= rd_data_ff.age;
                     hit_val_ff <= rd_data_ff.value;
                  end
                  if (!rd_entry_valid && !free_found_ff) begin
                     free_found_ff <= 1'b1;
                     free_slot_ff  <= rd_idx_ff;
                  end
                  if (rd_entry_valid && (rd_data_ff.age == AGE_OLDEST)) begin
                     old_slot_ff <= rd_idx_ff;
                  end
               end
               if (cnt_ff == CNT_LAST) begin
                  cnt_ff <= '0;
                  if (found_ff) begin
                     age_all_ff <= 1'b0;
                     state_ff   <= ST_UPDATE;
                  end else if (op_ff == lkvc_pkg::OP_INSERT) begin
                     state_ff <= ST_UPDATE;
                     if (free_found_ff) begin
                        slot_ff    <= free_slot_ff;
                        age_all_ff <= 1'b1;
                     end else begin
                        // full: replace the oldest entry
                        slot_ff    <= old_slot_ff;
                        limit_ff   <= AGE_OLDEST;
                        evict_ff   <= 1'b1;
                        age_all_ff <= 1'b0;
                     end
                  end else begin
                     // lookup miss leaves the store alone
                     state_ff <= ST_FINISH;
                  end
               end else begin
                  cnt_ff <= cnt_ff + CW'(1);
               end
            end
            ST_UPDATE: begin
               if (cnt_ff == CNT_LAST) begin
                  cnt_ff   <= '0;
                  state_ff <= ST_FINISH;
                  if ((op_ff == lkvc_pkg::OP_INSERT) && !found_ff) begin
                     valid_ff[slot_ff] <= 1'b1;
                  end
               end else begin
                  cnt_ff <= cnt_ff + CW'(1);
               end
            end
            ST_FINISH: begin
               if (!rsp_valid_ff || !rsp_stall) begin
                  rsp_valid_ff   <= 1'b1;
                  rsp_hit_ff     <= found_ff;
                  rsp_evicted_ff <= evict_ff;
                  if ((op_ff == lkvc_pkg::OP_LOOKUP) && found_ff) begin
                     rsp_data_ff <= lkvc_pkg::FIELD_W'(hit_val_ff[VI-1:0]);
                  end else begin
                     rsp_data_ff <= '0;
                  end
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   // only idle takes a new item
   assign req_stall   = (state_ff != ST_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_hit     = rsp_hit_ff;
   assign rsp_data    = rsp_data_ff;
   assign rsp_evicted = rsp_evicted_ff;

endmodule

`default_nettype wire

>>> hdl/lkvc_checker.sv
// port-level checks for the lru key-value cache, bound to the top level
`default_nettype none

module lkvc_checker (
   input wire logic                         clock,
   input wire logic                         reset,
   input wire logic                         req_valid,
   input wire logic                         req_stall,
   input wire logic                         rsp_valid,
   input wire logic                         rsp_stall,
   input wire logic                         rsp_hit,
   input wire logic [lkvc_pkg::FIELD_W-1:0] rsp_data,
   input wire logic                         rsp_evicted
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_hit) &&
                                 $stable(rsp_data) && $stable(rsp_evicted))
      else $error("stalled result changed");

   // an eviction only happens on an insert miss
   a_evict_miss: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_hit && rsp_evicted))
      else $error("eviction reported on a hit");

   // nonzero data only comes from a hit
   a_data_hit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data != '0) |-> rsp_hit)
      else $error("data returned without a hit");

   // busy right after taking an item
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second item taken while busy");

   // no result out of reset
   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind lru_key_value_cache lkvc_checker u_lkvc_checker (.*);

`default_nettype wire

>>> tb/tb.sv
// self-checking testbench for the lru key-value cache
`timescale 1ns / 100ps

module tb;

   localparam int CAP        = lkvc_pkg::DEF_CAPACITY;
   localparam int RANK_W     = $clog2(CAP);
   localparam int TAIL_WAIT  = 2 * CAP + 10;
   localparam int CYCLE_STOP = 250000;

   // low KEY_WIDTH / VALUE_WIDTH bits take part in matching and storing
   localparam logic [lkvc_pkg::FIELD_W-1:0] KEY_MASK =
      {lkvc_pkg::FIELD_W{1'b1}} >> (lkvc_pkg::FIELD_W - lkvc_pkg::DEF_KEY_WIDTH);
   localparam logic [lkvc_pkg::FIELD_W-1:0] VALUE_MASK =
      {lkvc_pkg::FIELD_W{1'b1}} >> (lkvc_pkg::FIELD_W - lkvc_pkg::DEF_VALUE_WIDTH);

   typedef struct packed {
      logic                         hit;
      logic [lkvc_pkg::FIELD_W-1:0] data;
      logic                         evicted;
   } cache_reply_type;

   // one row of the directed table; fixed marks a reply typed in by hand
   typedef struct packed {
      logic                         op;
      logic [lkvc_pkg::FIELD_W-1:0] key;
      logic [lkvc_pkg::FIELD_W-1:0] value;
      bit                           fixed;
      logic                         hit;
      logic [lkvc_pkg::FIELD_W-1:0] data;
      logic                         evicted;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                         req_valid     = 1'b0;
   logic                         req_stall;
   logic                         req_operation = lkvc_pkg::OP_LOOKUP;
   logic [lkvc_pkg::FIELD_W-1:0] req_key       = '0;
   logic [lkvc_pkg::FIELD_W-1:0] req_value     = '0;
   logic                         rsp_valid;
   logic                         rsp_stall     = 1'b0;
   logic                         rsp_hit;
   logic [lkvc_pkg::FIELD_W-1:0] rsp_data;
   logic                         rsp_evicted;

   // shadow copy of the cache contents and recency ranks
   logic [lkvc_pkg::FIELD_W-1:0] line_key   [CAP];
   logic [lkvc_pkg::FIELD_W-1:0] line_value [CAP];
   logic                         line_live  [CAP];
   logic [RANK_W-1:0]            line_rank  [CAP];
   logic [RANK_W:0]              line_count;

   cache_reply_type pending_replies[$];
   cache_reply_type oldest_reply;
   int unsigned     mismatch_count = 0;
   int unsigned     cycle_count    = 0;
   int unsigned     hold_left      = 0;
   bit              idling         = 1'b0;

   // directed items: empty cache, field extremes, update, fill to capacity,
   // eviction of the least recent entry and a lookup of the evicted key
   stim_row_type directed_rows [25] = '{
      '{lkvc_pkg::OP_LOOKUP, 32'h0000_0000, 32'h0000_0000, 1'b1, 1'b0, 32'h0000_0000, 1'b0},
      '{lkvc_pkg::OP_LOOKUP, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1, 1'b0, 32'h0000_0000, 1'b0},
      '{lkvc_pkg::OP_INSERT, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1, 1'b0, 32'h0000_0000, 1'b0},
      '{lkvc_pkg::OP_LOOKUP, 32'h0000_0000, 32'h0000_0000, 1'b1, 1'b1, 32'hFFFF_FFFF, 1'b0},
      '{lkvc_pkg::OP_INSERT, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1, 1'b0, 32'h0000_0000, 1'b0},
      '{lkvc_pkg::OP_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1, 32'h0000_0000, 1'b0},
      '{lkvc_pkg::OP_INSERT, 32'h0000_0000, 32'h1234_5678, 1'b1, 1'b1, 32'h0000_0000, 1'b0},
      '{lkvc_pkg::OP_LOOKUP, 32'h0000_0000, 32'h0000_0000, 1'b1, 1'b1, 32'h1234_5678, 1'b0},
      '{lkvc_pkg::OP_INSERT, 32'h0000_0100, 32'hA000_0000, 1'b0, 1'b0, 32'h0, 1'b0},
      '{lkvc_pkg::OP_INSERT, 32'h0000_0101, 32'hA000_0001, 1'b0, 1'b0, 32'h0, 1'b0},
      '{lkvc_pkg::OP_INSERT, 32'h0000_0102, 32'hA000_0002, 1'b0, 1'b0, 32'h0, 1'b0},
      '{lkvc_pkg::OP_INSERT, 32'h0000_0103, 32'hA000_0003, 1'b0, 1'b0, 32'h0, 1'b0},
      '{lkvc_pkg::OP_INSERT, 32'h0000_0104, 32'hA000_0004, 1'b0, 1'b0, 32'h0, 1'b0},
      '{lkvc_pkg::OP_INSERT, 32'h0000_0105, 32'hA000_0005, 1'b0, 1'b0, 32'h0, 1'b0},
      '{lkvc_pkg::OP_INSERT, 32'h0000_0106, 32'hA000_0006, 1'b0, 1'b0, 32'h0, 1'b0},
      '{lkvc_pkg::OP_INSERT, 32'h0000_0107, 32'hA000_0007, 1'b0, 1'b0, 32'h0, 1'b0},
      '{lkvc_pkg::OP_INSERT, 32'h0000_0108, 32'hA000_0008, 1'b0, 1'b0, 32'h0, 1'b0},
      '{lkvc_pkg::OP_INSERT, 32'h0000_0109, 32'hA000_0009, 1'b0, 1'b0, 32'h0, 1'b0},
      '{lkvc_pkg::OP_INSERT, 32'h0000_010A, 32'hA000_000A, 1'b0, 1'b0, 32'h0, 1'b0},
      '{lkvc_pkg::OP_INSERT, 32'h0000_010B, 32'hA000_000B, 1'b0, 1'b0, 32'h0, 1'b0},
      '{lkvc_pkg::OP_INSERT, 32'h0000_010C, 32'hA000_000C, 1'b0, 1'b0, 32'h0, 1'b0},
      '{lkvc_pkg::OP_INSERT, 32'h0000_010D, 32'hA000_000D, 1'b0, 1'b0, 32'h0, 1'b0},
      '{lkvc_pkg::OP_INSERT, 32'hA5A5_A5A5, 32'h5A5A_5A5A, 1'b1, 1'b0, 32'h0000_0000, 1'b1},
      '{lkvc_pkg::OP_LOOKUP, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1, 1'b0, 32'h0000_0000, 1'b0},
      '{lkvc_pkg::OP_LOOKUP, 32'h0000_0000, 32'h0000_0000, 1'b0, 1'b0, 32'h0, 1'b0}
   };

   lru_key_value_cache u_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_operation (req_operation),
      .req_key       (req_key),
      .req_value     (req_value),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_hit       (rsp_hit),
      .rsp_data      (rsp_data),
      .rsp_evicted   (rsp_evicted)
   );

   always #5 clock = ~clock;

   // make one entry the most recent; entries younger than it age by one
   function automatic void promote(int slot);
      logic [RANK_W-1:0] prior;
      prior = line_rank[slot];
      for (int i = 0; i < CAP; i++) begin
         if (line_live[i] && i != slot && line_rank[i] < prior) begin
            line_rank[i] = line_rank[i] + 1'b1;
         end
      end
      line_rank[slot] = '0;
   endfunction

   // apply one request to the shadow cache and return its reply
   function automatic cache_reply_type lru_access(logic op,
                                                  logic [lkvc_pkg::FIELD_W-1:0] key_in,
                                                  logic [lkvc_pkg::FIELD_W-1:0] value_in);
      cache_reply_type              reply;
      logic [lkvc_pkg::FIELD_W-1:0] k;
      logic [lkvc_pkg::FIELD_W-1:0] v;
      logic [RANK_W-1:0]            oldest;
      int                           slot;
      k     = key_in & KEY_MASK;
      v     = value_in & VALUE_MASK;
      reply = '0;
      slot  = -1;
      for (int i = 0; i < CAP; i++) begin
         if (slot < 0 && line_live[i] && line_key[i] == k) slot = i;
      end
      if (slot >= 0) begin
         // hit: lookup returns the word, insert overwrites it
         reply.hit = 1'b1;
         if (op == lkvc_pkg::OP_LOOKUP) reply.data = line_value[slot];
         else line_value[slot] = v;
         promote(slot);
      end else if (op == lkvc_pkg::OP_INSERT) begin
         if (line_count < CAP) begin
            // lowest free entry; every live entry ages by one
            for (int i = CAP - 1; i >= 0; i--) begin
               if (!line_live[i]) slot = i;
            end
            for (int i = 0; i < CAP; i++) begin
               if (line_live[i]) line_rank[i] = line_rank[i] + 1'b1;
            end
            line_live[slot] = 1'b1;
            line_count      = line_count + 1'b1;
         end else begin
            // full: replace the least recent entry
            oldest = '0;
            slot   = 0;
            for (int i = 0; i < CAP; i++) begin
               if (line_rank[i] > oldest) begin
                  oldest = line_rank[i];
                  slot   = i;
               end
            end
            promote(slot);
            reply.evicted = 1'b1;
         end
         line_key[slot]   = k;
         line_value[slot] = v;
         line_rank[slot]  = '0;
      end
      return reply;
   endfunction

   function automatic void compare_field(string name, logic [lkvc_pkg::FIELD_W-1:0] want_v,
                                         logic [lkvc_pkg::FIELD_W-1:0] got_v);
      if (got_v !== want_v) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want_v, got_v);
         mismatch_count++;
      end
   endfunction

   // present one item, wait for it to be taken, then queue its reply
   task automatic send_request(input logic op, input logic [lkvc_pkg::FIELD_W-1:0] key,
                               input logic [lkvc_pkg::FIELD_W-1:0] value, input bit fixed,
                               input cache_reply_type fixed_reply);
      int unsigned     gap;
      cache_reply_type predicted;
      gap = idling ? $urandom_range(5, 0) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_operation <= op;
      req_key       <= key;
      req_value     <= value;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predicted = lru_access(op, key, value);
      pending_replies.push_back(fixed ? fixed_reply : predicted);
   endtask

   // hold off the sender until every queued reply has come back
   task automatic wait_for_replies();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_replies.size() != 0) @(posedge clock);
   endtask

   // result side: check each item taken, draw the wait for the next one,
   // and count it down once that item shows up
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         hold_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_replies.size() == 0) begin
               $display("%0t: unexpected result, expected none, actual hit %0b data %h evicted %0b",
                        $time, rsp_hit, rsp_data, rsp_evicted);
               mismatch_count++;
            end else begin
               oldest_reply = pending_replies.pop_front();
               compare_field("hit", lkvc_pkg::FIELD_W'(oldest_reply.hit),
                             lkvc_pkg::FIELD_W'(rsp_hit));
               compare_field("data", oldest_reply.data, rsp_data);
               compare_field("evicted", lkvc_pkg::FIELD_W'(oldest_reply.evicted),
                             lkvc_pkg::FIELD_W'(rsp_evicted));
            end
            hold_left = idling ? $urandom_range(5, 0) : 0;
         end else if (rsp_valid && (hold_left > 0)) begin
            hold_left--;
         end
         rsp_stall <= (hold_left != 0);
      end
   end

   // run guard
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_STOP) begin
         $display("Verification failed");
         $finish;
      end
   end

   initial begin : stimulus
      logic [lkvc_pkg::FIELD_W-1:0] key_pool [48];
      int unsigned                  pool_sizes [5];
      int unsigned                  pool_used;
      logic                         op;
      logic [lkvc_pkg::FIELD_W-1:0] key;
      logic [lkvc_pkg::FIELD_W-1:0] value;
      cache_reply_type              typed_reply;

      pool_sizes = '{4, 16, 17, 24, 48};
      for (int i = 0; i < CAP; i++) begin
         line_key[i]   = '0;
         line_value[i] = '0;
         line_live[i]  = 1'b0;
         line_rank[i]  = '0;
      end
      line_count = '0;

      // key pool: extremes, random keys, and near neighbors one bit apart
      key_pool[0] = '0;
      key_pool[1] = '1;
      for (int i = 2; i < 24; i++) key_pool[i] = $urandom;
      for (int i = 24; i < 48; i++) begin
         key_pool[i] = key_pool[i - 24] ^ (32'h1 << $urandom_range(31, 0));
      end

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed table
      foreach (directed_rows[r]) begin
         typed_reply = '{directed_rows[r].hit, directed_rows[r].data, directed_rows[r].evicted};
         send_request(directed_rows[r].op, directed_rows[r].key, directed_rows[r].value,
                      directed_rows[r].fixed, typed_reply);
      end
      wait_for_replies();

      // random blocks: pool size sets the hit rate and how often the cache evicts
      for (int blk = 0; blk < 10; blk++) begin
         idling    = (blk != 0) && ($urandom_range(3, 0) != 0);
         pool_used = pool_sizes[$urandom_range(4, 0)];
         for (int n = 0; n < 100; n++) begin
            op = $urandom_range(1, 0) ? lkvc_pkg::OP_INSERT : lkvc_pkg::OP_LOOKUP;
            if ($urandom_range(9, 0) == 0) key = $urandom;
            else key = key_pool[$urandom_range(pool_used - 1, 0)];
            case ($urandom_range(9, 0))
               0: value = '0;
               1: value = '1;
               default: value = $urandom;
            endcase
            send_request(op, key, value, 1'b0, '0);
         end
         if (blk % 3 == 2) wait_for_replies();
      end

      // drain, then leave room for a stray result
      wait_for_replies();
      repeat (TAIL_WAIT) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

>>> sim.f
hdl/lkvc_pkg.sv
hdl/lru_key_value_cache.sv
hdl/lkvc_checker.sv
tb/tb.sv
